@@ rtl/lrc_pkg.sv @@
// Shared constants, types and codes for the LRC local XOR repair block.
`timescale 1ns / 1ps

package lrc_pkg;

    localparam int MAX_DATA   = 16;
    localparam int MAX_GROUPS = 8;
    localparam int WORD_BITS  = 64;

    // Derived widths
    localparam int KW = $clog2(MAX_DATA + 1);                      // block count
    localparam int BW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;     // block index
    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1; // group index
    localparam int LW = $clog2(MAX_GROUPS + 1);                    // group count

    // Field and register widths
    localparam int IDX_W   = 4;
    localparam int ND_W    = 5;
    localparam int NG_W    = 4;
    localparam int DMASK_W = 16;
    localparam int PMASK_W = 8;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    typedef enum logic [1:0] {
        REG_NUM_DATA,
        REG_NUM_GROUPS,
        REG_DATA_ERASED,
        REG_PARITY_ERASED
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_INIT,
        S_DIV,
        S_MAP,
        S_IDLE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              we;
        t_reg_idx          idx;
        logic [DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic build_start;
        logic div_step;
        logic map_step;
        logic accept;
        logic emit_start;
        logic emit_next;
        logic emit_load;
        logic acc_clear;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic map_done;
        logic cur_rep;
        logic cur_last_grp;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/lrc_ctrl.sv @@
// Control state machine: group map build, word intake and repair emission.
`timescale 1ns / 1ps

module lrc_ctrl import lrc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_last_of_column,
    input  logic  i_cfg_we,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        if (i_cfg_we) begin
            // any register write rebuilds the map from the new values
            n_state = S_INIT;
        end else begin
            unique case (r_state)
                S_INIT: begin
                    o_cmd.build_start = 1'b1;
                    n_state           = S_DIV;
                end
                S_DIV: begin
                    if (i_stat.div_done) begin
                        n_state = S_MAP;
                    end else begin
                        o_cmd.div_step = 1'b1;
                    end
                end
                S_MAP: begin
                    o_cmd.map_step = 1'b1;
                    if (i_stat.map_done) begin
                        n_state = S_IDLE;
                    end
                end
                S_IDLE: begin
                    o_stall = 1'b0;
                    if (i_valid) begin
                        o_cmd.accept = 1'b1;
                        if (i_last_of_column) begin
                            o_cmd.emit_start = 1'b1;
                            n_state          = S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (!i_stat.cur_rep || i_stat.out_free) begin
                        o_cmd.emit_load = i_stat.cur_rep;
                        o_cmd.emit_next = 1'b1;
                        if (i_stat.cur_last_grp) begin
                            o_cmd.acc_clear = 1'b1;
                            n_state         = S_IDLE;
                        end
                    end
                end
                default: begin
                    n_state = S_INIT;
                end
            endcase
        end
    end

endmodule

@@ rtl/lrc_dp.sv @@
// Datapath: registers, group map, erasure tally, accumulators, output stage.
`timescale 1ns / 1ps

module lrc_dp import lrc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg_wr              i_cfg,
    input  t_reg_idx             i_rd_idx,
    output logic [DATA_W-1:0]    o_rd_data,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_is_local_parity,
    input  logic [IDX_W-1:0]     i_block_index,
    input  logic [WORD_BITS-1:0] i_word,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [IDX_W-1:0]     o_repaired_index,
    output logic [WORD_BITS-1:0] o_repaired_word,
    output logic                 o_last_result
);

    logic [ND_W-1:0]    r_num_data;
    logic [NG_W-1:0]    r_num_groups;
    logic [DMASK_W-1:0] r_derased;
    logic [PMASK_W-1:0] r_perased;

    logic [KW-1:0] r_rem;
    logic [KW-1:0] r_q;
    logic [BW-1:0] r_bidx;
    logic [GW-1:0] r_grp;
    logic [KW-1:0] r_gcnt;

    logic [GW-1:0]        r_map    [MAX_DATA];
    logic [1:0]           r_ecnt   [MAX_GROUPS];
    logic [BW-1:0]        r_ewhich [MAX_GROUPS];
    logic [WORD_BITS-1:0] r_acc    [MAX_GROUPS];
    logic [GW-1:0]        r_eg;

    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_out_index;
    logic [WORD_BITS-1:0] r_out_word;
    logic                 r_out_last;

    logic [KW-1:0]         eff_k;
    logic [KW-1:0]         tmp_l;
    logic [LW-1:0]         eff_l;
    logic [KW-1:0]         grp_size;
    logic [MAX_GROUPS-1:0] rep;
    logic                  later_rep;
    logic                  in_hit;
    logic [GW-1:0]         in_grp;
    logic [GW-1:0]         acc_addr;
    logic [WORD_BITS-1:0]  acc_rd;
    logic                  out_free;

    // Clamped block and group counts
    always_comb begin
        if (r_num_data == '0) begin
            eff_k = KW'(1);
        end else if (r_num_data > ND_W'(MAX_DATA)) begin
            eff_k = KW'(MAX_DATA);
        end else begin
            eff_k = KW'(r_num_data);
        end
        tmp_l = (r_num_groups == '0) ? KW'(1) : KW'(r_num_groups);
        if (tmp_l > eff_k) begin
            tmp_l = eff_k;
        end
        if (tmp_l > KW'(MAX_GROUPS)) begin
            tmp_l = KW'(MAX_GROUPS);
        end
        eff_l = LW'(tmp_l);
    end

    // r_rem holds k mod l once the division is done
    assign grp_size = (KW'(r_grp) < r_rem) ? (r_q + KW'(1)) : r_q;

    always_comb begin
        later_rep = 1'b0;
        for (int g = 0; g < MAX_GROUPS; g++) begin
            rep[g] = (g < int'(eff_l)) && !r_perased[g] && (r_ecnt[g] == 2'd1);
            if (rep[g] && (g > int'(r_eg))) begin
                later_rep = 1'b1;
            end
        end
    end

    always_comb begin
        if (i_is_local_parity) begin
            in_grp = GW'(i_block_index);
            in_hit = (i_block_index < IDX_W'(eff_l)) && !r_perased[GW'(i_block_index)];
        end else begin
            in_grp = r_map[BW'(i_block_index)];
            in_hit = (KW'(i_block_index) < eff_k) && !r_derased[i_block_index];
        end
    end

    assign acc_addr = i_cmd.accept ? in_grp : r_eg;
    assign acc_rd   = r_acc[acc_addr];
    assign out_free = !r_out_valid || !i_stall;

    assign o_stat.div_done     = r_rem < KW'(eff_l);
    assign o_stat.map_done     = r_bidx == BW'(MAX_DATA - 1);
    assign o_stat.cur_rep      = rep[r_eg];
    assign o_stat.cur_last_grp = (LW'(r_eg) + LW'(1)) == eff_l;
    assign o_stat.out_free     = out_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_data   <= ND_W'(16);
            r_num_groups <= NG_W'(2);
            r_derased    <= '0;
            r_perased    <= '0;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                REG_NUM_DATA:      r_num_data   <= i_cfg.data[ND_W-1:0];
                REG_NUM_GROUPS:    r_num_groups <= i_cfg.data[NG_W-1:0];
                REG_DATA_ERASED:   r_derased    <= i_cfg.data[DMASK_W-1:0];
                REG_PARITY_ERASED: r_perased    <= i_cfg.data[PMASK_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (i_rd_idx)
            REG_NUM_DATA:      o_rd_data = DATA_W'(r_num_data);
            REG_NUM_GROUPS:    o_rd_data = DATA_W'(r_num_groups);
            REG_DATA_ERASED:   o_rd_data = DATA_W'(r_derased);
            REG_PARITY_ERASED: o_rd_data = DATA_W'(r_perased);
        endcase
    end

    // Map build: k/l by repeated subtraction, then one block per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_q    <= '0;
            r_bidx <= '0;
            r_grp  <= '0;
            r_gcnt <= '0;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                r_ecnt[g] <= '0;
            end
        end else if (i_cmd.build_start) begin
            r_rem  <= eff_k;
            r_q    <= '0;
            r_bidx <= '0;
            r_grp  <= '0;
            r_gcnt <= '0;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                r_ecnt[g] <= '0;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= r_rem - KW'(eff_l);
            r_q   <= r_q + KW'(1);
        end else if (i_cmd.map_step) begin
            r_bidx <= r_bidx + BW'(1);
            if (KW'(r_bidx) < eff_k) begin
                if (r_derased[r_bidx]) begin
                    r_ecnt[r_grp] <= (r_ecnt[r_grp] == 2'd2) ? 2'd2
                                                             : r_ecnt[r_grp] + 2'd1;
                end
                if ((r_gcnt + KW'(1)) == grp_size) begin
                    r_grp  <= r_grp + GW'(1);
                    r_gcnt <= '0;
                end else begin
                    r_gcnt <= r_gcnt + KW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.map_step) begin
            if (KW'(r_bidx) < eff_k) begin
                r_map[r_bidx] <= r_grp;
                if (r_derased[r_bidx]) begin
                    r_ewhich[r_grp] <= r_bidx;
                end
            end else begin
                r_map[r_bidx] <= '0;
            end
        end
    end

    // Group accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.acc_clear) begin
            for (int g = 0; g < MAX_GROUPS; g++) begin
                r_acc[g] <= '0;
            end
        end else if (i_cmd.accept && in_hit) begin
            r_acc[in_grp] <= acc_rd ^ i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eg <= '0;
        end else if (i_cmd.emit_start) begin
            r_eg <= '0;
        end else if (i_cmd.emit_next) begin
            r_eg <= r_eg + GW'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_index <= IDX_W'(r_ewhich[r_eg]);
            r_out_word  <= acc_rd;
            r_out_last  <= !later_rep;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_repaired_index = r_out_index;
    assign o_repaired_word  = r_out_word;
    assign o_last_result    = r_out_last;

endmodule

@@ rtl/lrc_local_xor_repair_top.sv @@
// Top level of the LRC local XOR repair block.
// Usage:
//   Input channel (i_valid / o_stall): surviving words of one column, data
//   or local-parity words, each XORed into its local group's accumulator.
//   Words for erased blocks or out-of-range indexes are dropped.
//   Output channel (o_valid / i_stall): one rebuilt word per group with
//   exactly one erased data block and a surviving local parity, ascending
//   group order, o_last_result on the final one of the column.
//   APB port: num_data at 0x0, num_groups at 0x4, data erased mask at 0x8,
//   parity erased mask at 0xC. pready is always high.
// Timing:
//   A non-final word is taken whenever o_stall is low. After the final word
//   of a column the emit sequencer walks the effective groups one per
//   cycle; a stalled output register holds that walk.
//   No new word is taken until the walk ends and accumulators are cleared.
// Reset and config:
//   After reset and every register write the group map is rebuilt (init, k/l by
//   repeated subtraction, a pass over all block slots), o_stall high meanwhile.
//   Reset clears the accumulators and the output valid flag.
`timescale 1ns / 1ps

module lrc_local_xor_repair_top import lrc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready,
    // input words
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_is_local_parity,
    input  logic [IDX_W-1:0]     i_block_index,
    input  logic [WORD_BITS-1:0] i_word,
    input  logic                 i_last_of_column,
    // repaired words
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [IDX_W-1:0]     o_repaired_index,
    output logic [WORD_BITS-1:0] o_repaired_word,
    output logic                 o_last_result
);

    t_cfg_wr  cfg;
    t_reg_idx rd_idx;
    t_cmd     cmd;
    t_stat    stat;

    // Register write completes in the access phase; no wait states.
    assign pready   = 1'b1;
    assign cfg.we   = psel && penable && pwrite;
    assign cfg.idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign cfg.data = pwdata;
    assign rd_idx   = t_reg_idx'(paddr[ADDR_W-1:2]);

    lrc_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_last_of_column (i_last_of_column),
        .i_cfg_we         (cfg.we),
        .i_stat           (stat),
        .o_cmd            (cmd),
        .o_stall          (o_stall)
    );

    lrc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_rd_idx          (rd_idx),
        .o_rd_data         (prdata),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_is_local_parity (i_is_local_parity),
        .i_block_index     (i_block_index),
        .i_word            (i_word),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_repaired_index  (o_repaired_index),
        .o_repaired_word   (o_repaired_word),
        .o_last_result     (o_last_result)
    );

endmodule

@@ rtl/lrc_chk.sv @@
// Port-level checker for the LRC local XOR repair block, with its bind.
`timescale 1ns / 1ps

module lrc_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic psel,
    input logic penable,
    input logic pwrite,
    input logic i_valid,
    input logic o_stall,
    input logic i_last_of_column,
    input logic o_valid,
    input logic i_stall
);

    // map build follows reset
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input not stalled after reset");

    // a register write starts a rebuild
    a_stall_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |=> o_stall)
        else $error("input not stalled after register write");

    // the column end blocks intake while repairs go out
    a_stall_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_of_column) |=> o_stall)
        else $error("input taken during repair emission");

    // a repaired word only appears during emission
    a_out_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("repaired word outside emission");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("output word dropped under stall");

endmodule

bind lrc_local_xor_repair_top lrc_chk u_lrc_chk (.*);
